// ===== design/cst_pkg.sv =====
// Package for the capability slot table: table size, field widths, entry type and codes.
// Used by capability_slot_table; has no dependencies of its own.
package cst_pkg;

    localparam int unsigned SLOTS         = 256;
    localparam int unsigned FIRST_DYNAMIC = 1;
    localparam int unsigned SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned SLOTIN_W = 8;
    localparam int unsigned TYPE_W   = 16;
    localparam int unsigned OBJ_W    = 32;
    localparam int unsigned RIGHTS_W = 64;
    localparam int unsigned FLAGS_W  = 64;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned IN_DATA_W  = 256;
    localparam int unsigned OUT_DATA_W = 192;

    localparam logic [FUNC_W-1:0] FUNC_INSTALL    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSTALL_AT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REVOKE     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0]   cap_type;
        logic [OBJ_W-1:0]    obj_ref;
        logic [RIGHTS_W-1:0] rights;
        logic [FLAGS_W-1:0]  flags;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

// ===== design/cst_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module cst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/capability_slot_table.sv =====
// Capability slot table top level: entry RAM, occupancy bitmap and one-item sequencer.
// Depends on cst_pkg and cst_ram.
//
//   channel   direction  ports                                   contents
//   s (item)  in         i_s_tvalid, o_s_tready, i_s_tdata       operation and entry fields
//   m (result) out       o_m_tvalid, i_m_tready, o_m_tdata       status, slot and found entry
//
// For each item, the transfer cycle issues the RAM read and the EXEC state then modifies
// and writes back. The RAM read port and the registered free-slot encoder set this split.
// A new item is taken while a result waits; execution holds while the output is full.
// Reset clears the occupancy bitmap at once, so the table starts empty with no sweep.
module capability_slot_table
    import cst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // func, slot, cap_type, obj_ref, rights, entry_flags, need_rights, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // status, slot_used, found_type, found_object, found_rights, found_flags, replaced, pad
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0]          r_state;
    logic [0:0]          n_state;
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    n_valid;
    logic [SLOT_W-1:0]   r_free_idx;
    logic [SLOT_W-1:0]   n_free_idx;
    logic                r_free_found;
    logic                n_free_found;

    logic [FUNC_W-1:0]   r_func;
    logic [SLOTIN_W-1:0] r_slot;
    t_entry              r_in_entry;
    logic [RIGHTS_W-1:0] r_req;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOTIN_W-1:0] r_out_slot;
    t_entry              r_out_entry;
    logic                r_out_replaced;

    logic [STATUS_W-1:0] n_status;
    logic [SLOTIN_W-1:0] n_slot_used;
    t_entry              n_found;
    logic                n_replaced;

    logic                in_fire;
    logic                exec_fire;
    logic                slot_bad;
    logic                slot_zero;
    logic [SLOT_W-1:0]   slot_idx;
    logic                cur_valid;
    t_entry              ram_q;
    t_entry              cur_entry;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;

    assign in_fire    = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign exec_fire  = (r_state == ST_EXEC) && (!r_out_valid || i_m_tready);

    assign slot_idx  = SLOT_W'(r_slot);
    assign slot_bad  = (32'(r_slot) >= SLOTS);
    assign slot_zero = (r_slot == '0);
    assign cur_valid = slot_bad ? 1'b0 : r_valid[slot_idx];
    assign cur_entry = cur_valid ? ram_q : '0;
    assign rd_addr   = (r_state == ST_IDLE) ? SLOT_W'(i_s_tdata[10:3]) : slot_idx;

    cst_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(r_in_entry),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    always_comb begin
        n_free_found = 1'b0;
        n_free_idx   = '0;
        for (int i = int'(SLOTS) - 1; i >= int'(FIRST_DYNAMIC); i--) begin
            if (!r_valid[i]) begin
                n_free_found = 1'b1;
                n_free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_status    = STATUS_OK;
        n_slot_used = '0;
        n_found     = '0;
        n_replaced  = 1'b0;
        n_valid     = r_valid;
        wr_en       = 1'b0;
        wr_addr     = slot_idx;
        case (r_func)
            FUNC_INSTALL: begin
                if (r_in_entry.cap_type == '0) begin
                    n_status = STATUS_BAD;
                end else if (!r_free_found) begin
                    n_status = STATUS_FULL;
                end else begin
                    wr_en               = exec_fire;
                    wr_addr             = r_free_idx;
                    n_valid[r_free_idx] = 1'b1;
                    n_slot_used         = SLOTIN_W'(32'(r_free_idx));
                end
            end
            FUNC_INSTALL_AT: begin
                if (slot_zero || slot_bad || r_in_entry.cap_type == '0) begin
                    n_status = STATUS_BAD;
                end else begin
                    n_replaced        = cur_valid;
                    wr_en             = exec_fire;
                    n_valid[slot_idx] = 1'b1;
                    n_slot_used       = r_slot;
                end
            end
            FUNC_READ: begin
                if (slot_bad) begin
                    n_status = STATUS_BAD;
                end else begin
                    n_found = cur_entry;
                end
            end
            FUNC_LOOKUP: begin
                if (slot_zero || slot_bad) begin
                    n_status = STATUS_BAD;
                end else if (cur_entry.cap_type != r_in_entry.cap_type ||
                             (cur_entry.rights & r_req) != r_req) begin
                    n_status = STATUS_MISMATCH;
                end else begin
                    n_found = cur_entry;
                end
            end
            FUNC_REVOKE: begin
                if (slot_zero || slot_bad) begin
                    n_status = STATUS_BAD;
                end else begin
                    n_replaced        = cur_valid;
                    n_valid[slot_idx] = 1'b0;
                end
            end
            FUNC_CLEAR: begin
                n_valid = '0;
            end
            default: begin
                n_status = STATUS_BAD;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_found <= n_free_found;
            if (exec_fire) begin
                r_valid     <= n_valid;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        if (in_fire) begin
            r_func               <= i_s_tdata[2:0];
            r_slot               <= i_s_tdata[10:3];
            r_in_entry.cap_type  <= i_s_tdata[26:11];
            r_in_entry.obj_ref   <= i_s_tdata[58:27];
            r_in_entry.rights    <= i_s_tdata[122:59];
            r_in_entry.flags     <= i_s_tdata[186:123];
            r_req                <= i_s_tdata[250:187];
        end
        if (exec_fire) begin
            r_out_status   <= n_status;
            r_out_slot     <= n_slot_used;
            r_out_entry    <= n_found;
            r_out_replaced <= n_replaced;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_replaced, r_out_entry.flags, r_out_entry.rights,
                         r_out_entry.obj_ref, r_out_entry.cap_type, r_out_slot,
                         r_out_status};

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_EXEC))
        else $error("accepted item did not enter execution");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> (r_out_valid && r_state == ST_IDLE))
        else $error("execution did not produce a result");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && r_func == FUNC_CLEAR) |=> (r_valid == '0))
        else $error("clear left occupied slots");

    a_install_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && r_func == FUNC_INSTALL && n_status == STATUS_OK)
        |=> r_valid[$past(r_free_idx)])
        else $error("install did not mark its slot occupied");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for capability_slot_table: directed, table-full and random operations.
// Depends on cst_pkg and the capability_slot_table RTL; predicts every result with a table mirror.
`timescale 1ns / 1ps

module tb_top;
    import cst_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [4:0]          pad;
        logic [RIGHTS_W-1:0] req;
        logic [FLAGS_W-1:0]  flags;
        logic [RIGHTS_W-1:0] rights;
        logic [OBJ_W-1:0]    obj;
        logic [TYPE_W-1:0]   cap_type;
        logic [SLOTIN_W-1:0] slot;
        logic [FUNC_W-1:0]   func;
    } t_item;

    typedef struct packed {
        logic [4:0]          pad;
        logic                replaced;
        logic [FLAGS_W-1:0]  found_flags;
        logic [RIGHTS_W-1:0] found_rights;
        logic [OBJ_W-1:0]    found_object;
        logic [TYPE_W-1:0]   found_type;
        logic [SLOTIN_W-1:0] slot_used;
        logic [STATUS_W-1:0] status;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // func, slot, cap_type, obj_ref, rights, entry_flags, need_rights, zero pad
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // status, slot_used, found_type, found_object, found_rights, found_flags, replaced, pad
    logic [OUT_DATA_W-1:0] o_m_tdata;

    t_entry  cap_mirror [SLOTS];
    t_result expected_results [$];
    int      error_count = 0;
    int      burst_left = 0;
    int      gap_next = 1;
    int      ready_mode = 0;
    int      mode_left = 0;
    logic [7:0] stall_shift = 8'b1011_0010;

    capability_slot_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_item make_item(input logic [FUNC_W-1:0] func,
                                        input logic [SLOTIN_W-1:0] slot,
                                        input logic [TYPE_W-1:0] cap_type,
                                        input logic [OBJ_W-1:0] obj,
                                        input logic [63:0] rights,
                                        input logic [63:0] flags,
                                        input logic [63:0] req);
        t_item it;
        it = '0;
        it.func = func;
        it.slot = slot;
        it.cap_type = cap_type;
        it.obj = obj;
        it.rights = rights;
        it.flags = flags;
        it.req = req;
        return it;
    endfunction

    function automatic t_entry entry_of(input t_item it);
        t_entry e;
        e.cap_type = it.cap_type;
        e.obj_ref = it.obj;
        e.rights = it.rights;
        e.flags = it.flags;
        return e;
    endfunction

    // Applies one operation to the table mirror and returns the result it must produce.
    function automatic t_result predict_result(input t_item it);
        t_result r;
        int      first_free;
        r = '0;
        first_free = -1;
        case (it.func)
            FUNC_INSTALL: begin
                if (it.cap_type == '0) begin
                    r.status = STATUS_BAD;
                end else begin
                    for (int i = FIRST_DYNAMIC; i < SLOTS; i++) begin
                        if (first_free < 0 && cap_mirror[i].cap_type == '0) first_free = i;
                    end
                    if (first_free < 0) begin
                        r.status = STATUS_FULL;
                    end else begin
                        cap_mirror[first_free] = entry_of(it);
                        r.slot_used = 8'(first_free);
                    end
                end
            end
            FUNC_INSTALL_AT: begin
                if (it.slot == '0 || int'(it.slot) >= SLOTS || it.cap_type == '0) begin
                    r.status = STATUS_BAD;
                end else begin
                    r.replaced = (cap_mirror[it.slot].cap_type != '0);
                    cap_mirror[it.slot] = entry_of(it);
                    r.slot_used = it.slot;
                end
            end
            FUNC_READ: begin
                if (int'(it.slot) >= SLOTS) begin
                    r.status = STATUS_BAD;
                end else begin
                    r.found_type = cap_mirror[it.slot].cap_type;
                    r.found_object = cap_mirror[it.slot].obj_ref;
                    r.found_rights = cap_mirror[it.slot].rights;
                    r.found_flags = cap_mirror[it.slot].flags;
                end
            end
            FUNC_LOOKUP: begin
                if (it.slot == '0 || int'(it.slot) >= SLOTS) begin
                    r.status = STATUS_BAD;
                end else if (cap_mirror[it.slot].cap_type != it.cap_type ||
                             (cap_mirror[it.slot].rights & it.req) != it.req) begin
                    r.status = STATUS_MISMATCH;
                end else begin
                    r.found_type = cap_mirror[it.slot].cap_type;
                    r.found_object = cap_mirror[it.slot].obj_ref;
                    r.found_rights = cap_mirror[it.slot].rights;
                    r.found_flags = cap_mirror[it.slot].flags;
                end
            end
            FUNC_REVOKE: begin
                if (it.slot == '0 || int'(it.slot) >= SLOTS) begin
                    r.status = STATUS_BAD;
                end else begin
                    r.replaced = (cap_mirror[it.slot].cap_type != '0);
                    cap_mirror[it.slot] = '0;
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) cap_mirror[i] = '0;
            end
            default: begin
                r.status = STATUS_BAD;
            end
        endcase
        return r;
    endfunction

    // Returns an occupied slot when there is one, else a random slot.
    function automatic logic [SLOTIN_W-1:0] pick_used_slot();
        int start;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            if (cap_mirror[(start + k) % SLOTS].cap_type != '0) return 8'((start + k) % SLOTS);
        end
        return 8'(start);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s, got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    // The sender works in bursts; a gap of zero keeps tvalid high into the next burst.
    task automatic send_item(input t_item it);
        if (gap_next > 0) repeat (gap_next) @(posedge i_clk);
        gap_next = 0;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= it;
        do @(posedge i_clk); while (!o_s_tready);
        expected_results.push_back(predict_result(it));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_next = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap_next > 0) i_s_tvalid <= 1'b0;
        end
    endtask

    // A nonzero gap means tvalid has already been dropped in this time step.
    task automatic wait_drain();
        if (gap_next == 0) i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        burst_left = 0;
        gap_next = 1;
    endtask

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        send_item(make_item(FUNC_INSTALL, 8'd9, '0, '1, ones, ones, '0));
        send_item(make_item(FUNC_INSTALL, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, ones, ones, ones));
        send_item(make_item(FUNC_INSTALL, 8'd255, 16'h0001, '0, 64'h00F0, '0, '0));
        send_item(make_item(FUNC_READ, 8'd0, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_READ, 8'd255, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_READ, 8'd1, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_LOOKUP, 8'd0, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_LOOKUP, 8'd1, 16'hFFFF, '0, '0, '0, ones));
        send_item(make_item(FUNC_LOOKUP, 8'd1, 16'hFFFE, '0, '0, '0, '0));
        send_item(make_item(FUNC_LOOKUP, 8'd2, 16'h0001, '0, '0, '0, 64'h01F0));
        send_item(make_item(FUNC_LOOKUP, 8'd2, 16'h0001, '0, '0, '0, 64'h0030));
        send_item(make_item(FUNC_LOOKUP, 8'd200, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_LOOKUP, 8'd200, '0, '0, '0, '0, 64'h1));
        send_item(make_item(FUNC_INSTALL_AT, 8'd0, 16'h0005, '1, ones, ones, '0));
        send_item(make_item(FUNC_INSTALL_AT, 8'd7, '0, '1, ones, ones, '0));
        send_item(make_item(FUNC_INSTALL_AT, 8'd255, 16'h8000, 32'h8000_0000,
                            64'h8000_0000_0000_0000, 64'h1, '0));
        send_item(make_item(FUNC_INSTALL_AT, 8'd1, 16'h0002, 32'h1234_5678, rand64(),
                            rand64(), '0));
        send_item(make_item(FUNC_REVOKE, 8'd0, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_REVOKE, 8'd100, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_REVOKE, 8'd1, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_INSTALL, 8'd0, 16'h0003, $urandom(), rand64(), rand64(), '0));
        send_item(make_item(FUNC_SPARE_6, 8'd1, 16'h0003, '1, ones, ones, ones));
        send_item(make_item(FUNC_SPARE_7, 8'd2, 16'h0001, '1, ones, ones, ones));
        send_item(make_item(FUNC_CLEAR, '0, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_READ, 8'd255, '0, '0, '0, '0, '0));
        wait_drain();
    endtask

    task automatic test_table_full();
        logic [SLOTIN_W-1:0] hole;
        hole = 8'($urandom_range(1, SLOTS - 1));
        for (int i = FIRST_DYNAMIC; i < SLOTS; i++) begin
            send_item(make_item(FUNC_INSTALL, '0, 16'($urandom_range(1, 65535)), $urandom(),
                                rand64(), rand64(), '0));
        end
        send_item(make_item(FUNC_INSTALL, '0, 16'h0042, $urandom(), rand64(), rand64(), '0));
        send_item(make_item(FUNC_INSTALL, '0, '0, $urandom(), rand64(), rand64(), '0));
        send_item(make_item(FUNC_REVOKE, hole, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_INSTALL, '0, 16'h0042, $urandom(), rand64(), rand64(), '0));
        send_item(make_item(FUNC_INSTALL, '0, 16'h0043, $urandom(), rand64(), rand64(), '0));
        send_item(make_item(FUNC_READ, 8'd255, '0, '0, '0, '0, '0));
        send_item(make_item(FUNC_CLEAR, '0, '0, '0, '0, '0, '0));
        wait_drain();
    endtask

    task automatic test_random(input int count);
        int                  sel;
        logic [SLOTIN_W-1:0] slot;
        logic [TYPE_W-1:0]   cap_type;
        t_item               it;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            slot = ($urandom_range(0, 1) == 0) ? pick_used_slot() : 8'($urandom_range(0, 255));
            cap_type = ($urandom_range(0, 19) == 0) ? '0 : 16'($urandom_range(1, 65535));
            it = make_item(FUNC_INSTALL, slot, cap_type, $urandom(), rand64(), rand64(),
                           rand64());
            if (sel < 30) begin
                it.func = FUNC_INSTALL;
            end else if (sel < 42) begin
                it.func = FUNC_INSTALL_AT;
            end else if (sel < 54) begin
                it.func = FUNC_READ;
            end else if (sel < 76) begin
                it.func = FUNC_LOOKUP;
                if ($urandom_range(0, 3) != 0) begin
                    it.slot = pick_used_slot();
                    it.cap_type = cap_mirror[it.slot].cap_type;
                    it.req = cap_mirror[it.slot].rights & rand64();
                end
            end else if (sel < 90) begin
                it.func = FUNC_REVOKE;
            end else if (sel < 92) begin
                it.func = FUNC_CLEAR;
            end else begin
                it.func = 3'($urandom_range(0, 7));
            end
            send_item(it);
        end
        wait_drain();
    endtask

    // The receiver switches between always ready, random, mostly stalled and a fixed rotation.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 200);
        end else begin
            mode_left--;
        end
        stall_shift = {stall_shift[6:0], stall_shift[7]};
        case (ready_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= stall_shift[0];
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_result got_r;
        t_result want_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_r = o_m_tdata;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result transfer", 64'(got_r.status), '0);
            end else begin
                want_r = expected_results.pop_front();
                if (got_r.status != want_r.status)
                    report_mismatch("status", 64'(got_r.status), 64'(want_r.status));
                if (got_r.slot_used != want_r.slot_used)
                    report_mismatch("slot_used", 64'(got_r.slot_used), 64'(want_r.slot_used));
                if (got_r.found_type != want_r.found_type)
                    report_mismatch("found_type", 64'(got_r.found_type), 64'(want_r.found_type));
                if (got_r.found_object != want_r.found_object)
                    report_mismatch("found_object", 64'(got_r.found_object),
                                    64'(want_r.found_object));
                if (got_r.found_rights != want_r.found_rights)
                    report_mismatch("found_rights", got_r.found_rights, want_r.found_rights);
                if (got_r.found_flags != want_r.found_flags)
                    report_mismatch("found_flags", got_r.found_flags, want_r.found_flags);
                if (got_r.replaced != want_r.replaced)
                    report_mismatch("replaced", 64'(got_r.replaced), 64'(want_r.replaced));
            end
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) cap_mirror[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_table_full();
        test_random(120);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== capability_slot_table.f =====
design/cst_pkg.sv
design/cst_ram.sv
design/capability_slot_table.sv
test/tb_top.sv
